// ----- rtl/core/assert_macros.svh -----
// assertion macros shared by the rtl of the link receiver
// no dependencies; active only when SYNTHESIS is not defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property holds in the same cycle
`define FTLR_ASSERT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// property holds in the following cycle
`define FTLR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define FTLR_ASSERT(lbl, clk, rst_n, ante, cons, msg)
`define FTLR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ----- rtl/core/ftlr_pkg.sv -----
// types and constants of the framed target link receiver
// no dependencies; imported by the parser and the top level
package ftlr_pkg;

	// request kind carried in s_tuser
	typedef enum logic {
		OP_BYTE = 1'b0,
		OP_TICK = 1'b1
	} op_t;

	// configuration register indexes
	localparam logic [1:0] CFG_HEADER  = 2'd0;
	localparam logic [1:0] CFG_TRAILER = 2'd1;
	localparam logic [1:0] CFG_TIMEOUT = 2'd2;

	// register reset values
	localparam logic [7:0] HEADER_RST  = 8'h88;
	localparam logic [7:0] TRAILER_RST = 8'h22;
	localparam logic [7:0] TIMEOUT_RST = 8'd60;

	// frame layout: header, then ten body bytes, eight of them data
	localparam logic [3:0] FRAME_BODY_LEN = 4'd10;
	localparam logic [3:0] DATA_BYTES     = 4'd8;

	// published values after reset
	localparam logic signed [15:0] SIZE_RST = 16'sd50;

	// frame completion event from the parser
	typedef struct packed {
		logic        done;
		logic [63:0] frame;
	} parse_evt_t;

endpackage

// ----- rtl/core/framed_target_link_receiver.sv -----
// Framed target link receiver. Each request is a serial byte (s_tuser = 0) or a
// periodic tick (s_tuser = 1) and produces exactly one result: the link flag, the
// last published target box and the published frame count. One request is taken
// every clock cycle while the result side is not stalled; a result is produced through
// the input register, then the state registers that also form the result register,
// and m_tready low stalls the input side once the input and result registers are full.
// A frame is a header byte, eight data bytes (four little-endian signed 16-bit
// values x, y, width, height), one ignored byte and the trailer byte; it is
// published on the next tick. Configuration writes take effect on the next cycle.
// depends on ftlr_pkg, ftlr_frame_parser and assert_macros.svh
`include "assert_macros.svh"
module framed_target_link_receiver import ftlr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// request stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // [7:0] rx_byte
	input  logic        s_tuser,  // [0] op
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	// [0] link_up, [16:1] target_x, [32:17] target_y, [48:33] target_width,
	// [64:49] target_height, [72:65] frames_seen, [79:73] zero
	output logic [79:0] m_tdata,
	// configuration writes
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data
);

	logic [7:0] header_q;
	logic [7:0] trailer_q;
	logic [7:0] timeout_q;

	logic       valid_s1;
	op_t        op_s1;
	logic [7:0] byte_s1;

	logic       m_tvalid_q;
	logic       advance;
	logic       proc;

	parse_evt_t evt;

	logic [63:0]       pending_q;
	logic [7:0]        ticks_q;
	logic signed [15:0] pub_x_q;
	logic signed [15:0] pub_y_q;
	logic signed [15:0] pub_w_q;
	logic signed [15:0] pub_h_q;
	logic [7:0]        frame_cnt_q;
	logic              link_q;

	logic [7:0] ticks_inc;
	logic       publish;
	logic       drop;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_q  <= HEADER_RST;
			trailer_q <= TRAILER_RST;
			timeout_q <= TIMEOUT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_HEADER:  header_q  <= cfg_data;
				CFG_TRAILER: trailer_q <= cfg_data;
				CFG_TIMEOUT: timeout_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// handshake: state and result advance together
	assign advance  = !m_tvalid_q || m_tready;
	assign s_tready = !valid_s1 || advance;
	assign proc     = valid_s1 && advance;
	assign m_tvalid = m_tvalid_q;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			op_s1   <= op_t'(s_tuser);
			byte_s1 <= s_tdata;
		end
	end

	// frame parser
	ftlr_frame_parser u_parser (
		.clk          (clk),
		.arst_n       (arst_n),
		.byte_en      (proc && op_s1 == OP_BYTE),
		.rx_byte      (byte_s1),
		.header_byte  (header_q),
		.trailer_byte (trailer_q),
		.evt          (evt)
	);

	// tick count with saturation, publish and timeout decisions
	always_comb begin
		ticks_inc = (ticks_q != 8'hFF) ? ticks_q + 8'd1 : ticks_q;
		publish   = ticks_inc == 8'd1;
		drop      = ticks_inc >= timeout_q;
	end

	// link state and published values, also the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q   <= '0;
			ticks_q     <= 8'd1;
			pub_x_q     <= '0;
			pub_y_q     <= '0;
			pub_w_q     <= SIZE_RST;
			pub_h_q     <= SIZE_RST;
			frame_cnt_q <= '0;
			link_q      <= 1'b0;
			m_tvalid_q  <= 1'b0;
		end else begin
			if (advance) begin
				m_tvalid_q <= valid_s1;
			end
			if (proc) begin
				if (op_s1 == OP_TICK) begin
					ticks_q <= drop ? 8'd1 : ticks_inc;
					// a publishing tick that also times out leaves the link down
					if (publish) begin
						pub_x_q     <= pending_q[15:0];
						pub_y_q     <= pending_q[31:16];
						pub_w_q     <= pending_q[47:32];
						pub_h_q     <= pending_q[63:48];
						frame_cnt_q <= frame_cnt_q + 8'd1;
						link_q      <= !drop;
					end else if (drop) begin
						link_q <= 1'b0;
					end
				end else if (evt.done) begin
					pending_q <= evt.frame;
					ticks_q   <= '0;
				end
			end
		end
	end

	assign m_tdata = {7'd0, frame_cnt_q, pub_h_q, pub_w_q, pub_y_q, pub_x_q, link_q};

	// bytes never publish, and a stalled input side means the input register is full
	`FTLR_ASSERT_NEXT(a_byte_no_publish, clk, arst_n, proc && op_s1 == OP_BYTE, $stable(frame_cnt_q) && $stable(pub_x_q), "byte request changed published state")
	`FTLR_ASSERT(a_stall_full, clk, arst_n, !s_tready, valid_s1 && m_tvalid_q && !m_tready, "input stalled without a full pipeline")
	`FTLR_ASSERT_NEXT(a_accepted_flows, clk, arst_n, proc, m_tvalid_q, "processed request gave no result")

endmodule

// ----- rtl/core/ftlr_frame_parser.sv -----
// serial frame parser: header hunt, body byte count, data staging, trailer check
// depends on ftlr_pkg
module ftlr_frame_parser import ftlr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       byte_en,
	input  logic [7:0] rx_byte,
	input  logic [7:0] header_byte,
	input  logic [7:0] trailer_byte,
	output parse_evt_t evt
);

	logic        collecting_q;
	logic [3:0]  byte_index_q;
	logic [63:0] staging_q;
	logic [3:0]  idx_next;
	logic        body_end;

	assign idx_next = byte_index_q + 4'd1;
	assign body_end = idx_next >= FRAME_BODY_LEN;

	// hunt / collect control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			collecting_q <= 1'b0;
			byte_index_q <= '0;
		end else if (byte_en) begin
			if (!collecting_q) begin
				if (rx_byte == header_byte) begin
					collecting_q <= 1'b1;
					byte_index_q <= '0;
				end
			end else if (body_end) begin
				collecting_q <= 1'b0;
				byte_index_q <= '0;
			end else begin
				byte_index_q <= idx_next;
			end
		end
	end

	// data bytes shift in from the top, first data byte ends in the low byte
	always_ff @(posedge clk) begin
		if (byte_en && collecting_q && idx_next <= DATA_BYTES) begin
			staging_q <= {rx_byte, staging_q[63:8]};
		end
	end

	// frame accepted on a matching trailer
	always_comb begin
		evt.done  = byte_en && collecting_q && body_end && (rx_byte == trailer_byte);
		evt.frame = staging_q;
	end

endmodule
